// File: sv/ptb_pkg.sv
// Shared constants, types and state codes of the palindromic tree builder.
package ptb_pkg;

  localparam int MAX_LEN  = 4096;
  localparam int NODE_CAP = MAX_LEN + 2;
  localparam int NW       = $clog2(NODE_CAP);
  localparam int PW       = $clog2(MAX_LEN + 1);
  localparam int AW       = $clog2(MAX_LEN);
  localparam int ROW_W    = 4 * NW;

  localparam logic [NW-1:0] ROOT_IMAG  = NW'(0);
  localparam logic [NW-1:0] ROOT_EMPTY = NW'(1);

  localparam logic [1:0] SYM_A     = 2'd0;
  localparam logic [1:0] SYM_C     = 2'd1;
  localparam logic [1:0] SYM_T     = 2'd2;
  localparam logic [1:0] SYM_OTHER = 2'd3;

  typedef struct packed {
    logic [1:0] sym;
    logic       restart;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } item_chan_t;

  typedef enum logic [3:0] {
    S_IDLE, S_WRD, S_WLEN, S_WSYM, S_CRD, S_CGET, S_QRD, S_QGET,
    S_WR_NEW, S_WR_PAR, S_RRD, S_RLEN, S_OUT
  } state_t;

  function automatic logic [1:0] map_symbol(input logic [7:0] c);
    logic [1:0] s;
    unique case (c)
      8'h41:   s = SYM_A;
      8'h43:   s = SYM_C;
      8'h54:   s = SYM_T;
      default: s = SYM_OTHER;
    endcase
    return s;
  endfunction

endpackage

// File: sv/ptb_ram.sv
// Generic single-port RAM with registered read data.
module ptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/ptb_front.sv
// Front end: maps characters to symbols and buffers them in a two-entry queue.
module ptb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          base_char,
  input  logic                restart,
  output ptb_pkg::item_chan_t chan,
  input  logic                take
);

  ptb_pkg::item_t q [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = take && (count != 2'd0);

  assign chan.valid = (count != 2'd0);
  assign chan.item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= '{sym: ptb_pkg::map_symbol(base_char), restart: restart};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// File: sv/ptb_engine.sv
// Back end: suffix-link walks, node creation and the result register.
module ptb_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  ptb_pkg::item_chan_t          chan,
  output logic                         take,
  output logic                         empty,
  input  logic                         pop,
  output logic [12:0]                  suffix_pal_len,
  output logic [12:0]                  suffix_node,
  output logic                         created,
  output logic [12:0]                  distinct_count,
  output logic                         overflow
);

  localparam int NW    = ptb_pkg::NW;
  localparam int PW    = ptb_pkg::PW;
  localparam int AW    = ptb_pkg::AW;
  localparam int ROW_W = ptb_pkg::ROW_W;

  ptb_pkg::state_t state, state_next;

  logic [PW-1:0]    pos;
  logic [NW-1:0]    last;
  logic [NW-1:0]    node_count;
  logic [ROW_W-1:0] root_row [2];
  logic [1:0]       csym;
  logic [NW-1:0]    w;
  logic [NW-1:0]    par;
  logic [NW-1:0]    lnk;
  logic [NW-1:0]    hlen;
  logic [NW-1:0]    newl;
  logic [NW-1:0]    newlink;
  logic [ROW_W-1:0] par_row;
  logic             phase_b;
  logic [NW-1:0]    res_len;
  logic             res_created;
  logic             res_ovf;
  logic             out_valid;

  logic [PW-1:0]    eff_pos;
  logic [NW-1:0]    eff_last;
  logic [NW-1:0]    eff_count;

  logic             sym_we;
  logic [AW-1:0]    sym_addr;
  logic [1:0]       sym_rdata;
  logic             node_we;
  logic [NW-1:0]    node_addr;
  logic [NW-1:0]    len_rdata;
  logic [NW-1:0]    link_rdata;
  logic             child_we;
  logic [NW-1:0]    child_addr;
  logic [ROW_W-1:0] child_wdata;
  logic [ROW_W-1:0] child_rdata;

  logic [NW-1:0]    cur_len;
  logic [NW-1:0]    cur_link;
  logic signed [NW:0] idx;
  logic [ROW_W-1:0] row_sel;
  logic [NW-1:0]    child_sel;
  logic [ROW_W-1:0] par_row_upd;
  logic             out_load;

  ptb_ram #(.WIDTH(2), .DEPTH(ptb_pkg::MAX_LEN)) u_sym (
    .clk(clk), .we(sym_we), .addr(sym_addr), .wdata(chan.item.sym), .rdata(sym_rdata)
  );
  ptb_ram #(.WIDTH(NW), .DEPTH(ptb_pkg::NODE_CAP)) u_len (
    .clk(clk), .we(node_we), .addr(node_addr), .wdata(newl), .rdata(len_rdata)
  );
  ptb_ram #(.WIDTH(NW), .DEPTH(ptb_pkg::NODE_CAP)) u_link (
    .clk(clk), .we(node_we), .addr(node_addr), .wdata(newlink), .rdata(link_rdata)
  );
  ptb_ram #(.WIDTH(ROW_W), .DEPTH(ptb_pkg::NODE_CAP)) u_child (
    .clk(clk), .we(child_we), .addr(child_addr), .wdata(child_wdata), .rdata(child_rdata)
  );

  assign eff_pos   = chan.item.restart ? '0 : pos;
  assign eff_last  = chan.item.restart ? ptb_pkg::ROOT_IMAG : last;
  assign eff_count = chan.item.restart ? NW'(2) : node_count;

  assign cur_len  = (w == ptb_pkg::ROOT_EMPTY) ? '0 : len_rdata;
  assign cur_link = (w == ptb_pkg::ROOT_EMPTY) ? ptb_pkg::ROOT_IMAG : link_rdata;
  assign idx      = $signed({1'b0, NW'(pos)}) - $signed({1'b0, cur_len}) - (NW+1)'(1);
  assign row_sel  = (w < NW'(2)) ? root_row[w[0]] : child_rdata;
  assign child_sel = row_sel[csym*NW +: NW];

  always_comb begin
    par_row_upd = par_row;
    par_row_upd[csym*NW +: NW] = node_count;
  end

  assign out_load = (state == ptb_pkg::S_OUT) && (!out_valid || pop);
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    take        = 1'b0;
    sym_we      = 1'b0;
    sym_addr    = AW'(eff_pos);
    node_we     = 1'b0;
    node_addr   = w;
    child_we    = 1'b0;
    child_addr  = w;
    child_wdata = '0;
    unique case (state)
      ptb_pkg::S_IDLE: begin
        if (chan.valid) begin
          take = 1'b1;
          if (eff_pos >= PW'(ptb_pkg::MAX_LEN)) begin
            state_next = ptb_pkg::S_RRD;
          end else begin
            sym_we     = 1'b1;
            state_next = ptb_pkg::S_WRD;
          end
        end
      end
      ptb_pkg::S_WRD: state_next = ptb_pkg::S_WLEN;
      ptb_pkg::S_WLEN: begin
        sym_addr = AW'(idx - (NW+1)'(1));
        if (w == ptb_pkg::ROOT_IMAG) begin
          state_next = phase_b ? ptb_pkg::S_QRD : ptb_pkg::S_CRD;
        end else if (idx < $signed((NW+1)'(1))) begin
          state_next = ptb_pkg::S_WRD;
        end else begin
          state_next = ptb_pkg::S_WSYM;
        end
      end
      ptb_pkg::S_WSYM: begin
        if (sym_rdata == csym) begin
          state_next = phase_b ? ptb_pkg::S_QRD : ptb_pkg::S_CRD;
        end else begin
          state_next = ptb_pkg::S_WRD;
        end
      end
      ptb_pkg::S_CRD: state_next = ptb_pkg::S_CGET;
      ptb_pkg::S_CGET: begin
        if (child_sel != '0) begin
          state_next = ptb_pkg::S_RRD;
        end else if (node_count < NW'(ptb_pkg::NODE_CAP)) begin
          state_next = (par == ptb_pkg::ROOT_IMAG) ? ptb_pkg::S_WR_NEW : ptb_pkg::S_WRD;
        end else begin
          state_next = ptb_pkg::S_RRD;
        end
      end
      ptb_pkg::S_QRD: state_next = ptb_pkg::S_QGET;
      ptb_pkg::S_QGET: state_next = ptb_pkg::S_WR_NEW;
      ptb_pkg::S_WR_NEW: begin
        node_we    = 1'b1;
        node_addr  = node_count;
        child_we   = 1'b1;
        child_addr = node_count;
        state_next = ptb_pkg::S_WR_PAR;
      end
      ptb_pkg::S_WR_PAR: begin
        child_we    = (par >= NW'(2));
        child_addr  = par;
        child_wdata = par_row_upd;
        state_next  = ptb_pkg::S_OUT;
      end
      ptb_pkg::S_RRD: begin
        node_addr  = last;
        state_next = ptb_pkg::S_RLEN;
      end
      ptb_pkg::S_RLEN: state_next = ptb_pkg::S_OUT;
      ptb_pkg::S_OUT: begin
        if (!out_valid || pop) state_next = ptb_pkg::S_IDLE;
      end
      default: state_next = ptb_pkg::S_IDLE;
    endcase
  end

  // Datapath registers follow the state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      last        <= ptb_pkg::ROOT_IMAG;
      node_count  <= NW'(2);
      root_row[0] <= '0;
      root_row[1] <= '0;
      out_valid   <= 1'b0;
      phase_b     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ptb_pkg::S_IDLE: begin
          if (chan.valid) begin
            if (chan.item.restart) begin
              root_row[0] <= '0;
              root_row[1] <= '0;
            end
            node_count  <= eff_count;
            last        <= eff_last;
            csym        <= chan.item.sym;
            w           <= eff_last;
            phase_b     <= 1'b0;
            res_created <= 1'b0;
            if (eff_pos >= PW'(ptb_pkg::MAX_LEN)) begin
              pos     <= eff_pos;
              res_ovf <= 1'b1;
            end else begin
              pos     <= eff_pos + PW'(1);
              res_ovf <= 1'b0;
            end
          end
        end
        ptb_pkg::S_WLEN: begin
          hlen <= cur_len;
          lnk  <= cur_link;
          if (w == ptb_pkg::ROOT_IMAG) begin
            if (!phase_b) begin
              par  <= w;
              newl <= NW'(1);
            end
          end else if (idx < $signed((NW+1)'(1))) begin
            w <= cur_link;
          end
        end
        ptb_pkg::S_WSYM: begin
          if (sym_rdata == csym) begin
            if (!phase_b) begin
              par  <= w;
              newl <= hlen + NW'(2);
            end
          end else begin
            w <= lnk;
          end
        end
        ptb_pkg::S_CGET: begin
          par_row <= row_sel;
          if (child_sel != '0) begin
            last <= child_sel;
          end else if (node_count < NW'(ptb_pkg::NODE_CAP)) begin
            newlink <= ptb_pkg::ROOT_EMPTY;
            phase_b <= 1'b1;
            w       <= lnk;
          end
        end
        ptb_pkg::S_QGET: begin
          newlink <= (child_sel < NW'(ptb_pkg::NODE_CAP)) ? child_sel : ptb_pkg::ROOT_IMAG;
        end
        ptb_pkg::S_WR_PAR: begin
          if (par < NW'(2)) root_row[par[0]] <= par_row_upd;
          last        <= node_count;
          node_count  <= node_count + NW'(1);
          res_len     <= newl;
          res_created <= 1'b1;
        end
        ptb_pkg::S_RLEN: begin
          if (last == ptb_pkg::ROOT_IMAG) begin
            res_len <= '1;
          end else if (last == ptb_pkg::ROOT_EMPTY) begin
            res_len <= '0;
          end else begin
            res_len <= len_rdata;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      suffix_pal_len <= 13'(res_len);
      suffix_node    <= 13'(last);
      created        <= res_created;
      distinct_count <= 13'(node_count - NW'(2));
      overflow       <= res_ovf;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    node_count <= NW'(ptb_pkg::NODE_CAP) && node_count >= NW'(2))
    else $error("node count out of range");
  a_ovf_not_created: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(overflow && created))
    else $error("overflow result marked as created");
  a_new_is_newest: assert property (@(posedge clk) disable iff (rst)
    out_load && res_created |-> last == node_count - NW'(1))
    else $error("created node is not the newest node");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    take |-> state == ptb_pkg::S_IDLE && chan.valid)
    else $error("item taken outside idle");

endmodule

// File: sv/palindromic_tree_builder.sv
// The back end takes one transaction at a time and finishes it before it takes the next. It
// walks suffix links, each hop reading the node length and then the symbol store, and skipping
// the symbol read when the mirror lies before the string; a new node whose parent is not the
// imaginary root needs a second walk for its suffix link; an overflowing transaction skips it.
// Reset (synchronous, rst high) empties the front-end queue and the result register and restores
// the two roots; no RAM sweep.
module palindromic_tree_builder (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  base_char,
  input  logic        restart,
  output logic        empty,
  input  logic        pop,
  output logic [12:0] suffix_pal_len,
  output logic [12:0] suffix_node,
  output logic        created,
  output logic [12:0] distinct_count,
  output logic        overflow
);

  // The channel carries mapped symbols from the front end to the back end.
  ptb_pkg::item_chan_t chan;
  logic                take;

  // The front end classifies each character and queues the transaction.
  ptb_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .base_char(base_char), .restart(restart), .chan(chan), .take(take)
  );

  // The back end walks suffix links, creates nodes and presents results.
  ptb_engine u_engine (
    .clk(clk), .rst(rst), .chan(chan), .take(take), .empty(empty), .pop(pop),
    .suffix_pal_len(suffix_pal_len), .suffix_node(suffix_node), .created(created),
    .distinct_count(distinct_count), .overflow(overflow)
  );

endmodule

// File: verif/ptb_checker.sv
// Result checker for the palindromic tree builder: predicts each transaction and compares.
`timescale 1ns / 1ps

module ptb_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  base_char,
  input  logic        restart,
  input  logic        empty,
  input  logic        pop,
  input  logic [12:0] suffix_pal_len,
  input  logic [12:0] suffix_node,
  input  logic        created,
  input  logic [12:0] distinct_count,
  input  logic        overflow,
  output int          fail_count,
  output int          pending,
  output int          n_created,
  output int          n_overflow,
  output int          n_results
);

  typedef struct packed {
    logic [12:0] len;
    logic [12:0] node;
    logic        made;
    logic [12:0] count;
    logic        ovf;
  } pal_result_t;

  pal_result_t expected_q[$];

  logic [1:0]  sym_mem [ptb_pkg::MAX_LEN];
  int          kid [ptb_pkg::NODE_CAP][4];
  int          slink [ptb_pkg::NODE_CAP];
  int          plen [ptb_pkg::NODE_CAP];
  int          nodes, tail_node, str_len;

  function automatic void clear_tree();
    for (int s = 0; s < 4; s++) begin
      kid[0][s] = 0;
      kid[1][s] = 0;
    end
    plen[0] = -1;
    plen[1] = 0;
    slink[0] = 0;
    slink[1] = 0;
    nodes = 2;
    tail_node = 0;
    str_len = 0;
  endfunction

  // Walks suffix links until the palindrome at w can be wrapped by symbol s.
  function automatic int find_extendable(int w, logic [1:0] s, int pos);
    int idx;
    int hops;
    hops = 0;
    forever begin
      if (w == 0) return 0;
      idx = pos - plen[w] - 1;
      if (idx >= 1 && sym_mem[idx-1] == s) return w;
      hops++;
      if (hops > ptb_pkg::NODE_CAP) return 0;
      w = slink[w];
    end
  endfunction

  function automatic pal_result_t add_symbol(logic [7:0] c, logic rs);
    pal_result_t r;
    logic [1:0]  s;
    int          w, q, n;
    s = (c == "A") ? ptb_pkg::SYM_A : (c == "C") ? ptb_pkg::SYM_C :
        (c == "T") ? ptb_pkg::SYM_T : ptb_pkg::SYM_OTHER;
    r = '0;
    if (rs) clear_tree();
    if (str_len >= ptb_pkg::MAX_LEN) begin
      r.ovf = 1'b1;
    end else begin
      str_len++;
      sym_mem[str_len-1] = s;
      w = find_extendable(tail_node, s, str_len);
      if (kid[w][s] != 0) begin
        tail_node = kid[w][s];
      end else if (nodes < ptb_pkg::NODE_CAP) begin
        n = nodes;
        plen[n] = plen[w] + 2;
        if (w == 0) begin
          slink[n] = 1;
        end else begin
          q = find_extendable(slink[w], s, str_len);
          slink[n] = kid[q][s];
        end
        for (int k = 0; k < 4; k++) kid[n][k] = 0;
        kid[w][s] = n;
        nodes = n + 1;
        tail_node = n;
        r.made = 1'b1;
      end
    end
    r.len = 13'(plen[tail_node]);
    r.node = 13'(tail_node);
    r.count = 13'(nodes - 2);
    return r;
  endfunction

  initial begin
    fail_count = 0;
    n_created = 0;
    n_overflow = 0;
    n_results = 0;
    clear_tree();
  end

  assign pending = expected_q.size();

  always @(posedge clk) begin
    pal_result_t exp_r, got;
    if (rst) begin
      expected_q.delete();
      clear_tree();
    end else begin
      if (push && !full) expected_q.push_back(add_symbol(base_char, restart));
      if (pop && !empty) begin
        got = '{suffix_pal_len, suffix_node, created, distinct_count, overflow};
        n_results++;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("ERROR: result with nothing expected: %p", got);
        end else begin
          exp_r = expected_q.pop_front();
          n_created += exp_r.made;
          n_overflow += exp_r.ovf;
          if (got !== exp_r) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: mismatch at t=%0t expected %p got %p", $realtime, exp_r, got);
          end
        end
      end
    end
  end
endmodule

// File: verif/tb_palindromic_tree_builder.sv
// Top of the palindromic tree builder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_palindromic_tree_builder;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [7:0]  base_char = 8'h41;
  logic        restart = 1'b0;
  logic        full, empty, created, overflow;
  logic [12:0] suffix_pal_len, suffix_node, distinct_count;
  int          fail_count, pending, n_created, n_overflow, n_results;
  int          hold_off;
  int          items_sent;
  bit          stim_done;
  string       pattern = "ACACATTACAC";

  palindromic_tree_builder DUT (.*);

  ptb_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Short gaps usually, and now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one transaction from the falling edge and holds it until it is taken.
  // Push stays high afterwards so that the next transaction can follow at once.
  task automatic send(input logic [7:0] c, input logic rs);
    base_char <= c;
    restart <= rs;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Drops push for the length of gap g, and leaves it high if g is zero.
  task automatic pause(input int g);
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic send_gapped(input logic [7:0] c, input logic rs);
    int g;
    g = gap_len();
    send(c, rs);
    pause(g);
  endtask

  function automatic logic [7:0] dna_char(input bit noisy);
    int r;
    r = $urandom_range(0, 3);
    if (noisy && $urandom_range(0, 9) == 0) return 8'($urandom);
    case (r)
      0: return "A";
      1: return "C";
      2: return "T";
      default: return "G";
    endcase
  endfunction

  // Receiver: random stalls, with one long hold-off during the back-to-back run so that
  // the block fills up and pushes back on the sender.
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off > 0) begin
        pop <= 1'b0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        @(negedge clk);
        repeat (gap_len()) @(negedge clk);
      end else begin
        pop <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    hold_off = 0;
    items_sent = 0;
    stim_done = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: palindromes of every symbol, odd bytes, restarts.
    send("A", 1'b1);
    foreach (pattern[i]) send_gapped(pattern[i], 1'b0);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send("G", 1'b0);
    send(8'hFF, 1'b0);
    send(8'h00, 1'b0);
    send("T", 1'b1);
    send("T", 1'b0);
    send("T", 1'b0);
    send(8'h61, 1'b0);
    send("C", 1'b1);

    // A long back-to-back run from a restart while the receiver holds off, so that the block
    // fills up, then one more restart.
    hold_off = 300;
    for (int i = 0; i < 80; i++) send(dna_char(1'b0), (i == 0));
    send("A", 1'b0);
    send(8'h00, 1'b0);
    send("C", 1'b1);

    // Random: strings rich in A and T, with some noise and occasional restarts.
    for (int i = 0; i < 1000; i++) begin
      logic [7:0] c;
      if ($urandom_range(0, 1) == 0) c = dna_char(1'b1);
      else c = ($urandom_range(0, 1) == 0) ? "A" : "T";
      send_gapped(c, ($urandom_range(0, 59) == 0));
    end
    push <= 1'b0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d transactions; %0d results checked, %0d new nodes, %0d overflows.",
             items_sent, n_results, n_created, n_overflow);
    if (fail_count == 0 && pending == 0) begin
      $display("palindromic_tree_builder test passed");
    end else begin
      $display("palindromic_tree_builder test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("palindromic_tree_builder test failed");
    $finish;
  end
endmodule

// File: files.f
sv/ptb_pkg.sv
sv/ptb_ram.sv
sv/ptb_front.sv
sv/ptb_engine.sv
sv/palindromic_tree_builder.sv
verif/ptb_checker.sv
verif/tb_palindromic_tree_builder.sv
